[rtl/pmau_pkg.sv]
// ----------------------------------------------------------------------------
// pmau_pkg: shared types and codes of the prime modulus arithmetic unit
// Operation codes, operand widths and write-back targets of the reduce unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pmau_pkg;

  localparam int unsigned MOD_W = 31;
  localparam int unsigned OPD_W = 64;
  localparam int unsigned EXP_W = 63;

  typedef logic [MOD_W-1:0] res_t;
  typedef logic [2:0]       func_t;
  typedef logic [2:0]       dst_t;

  // operation codes
  localparam func_t FN_ADD = 3'd0;
  localparam func_t FN_SUB = 3'd1;
  localparam func_t FN_MUL = 3'd2;
  localparam func_t FN_DIV = 3'd3;
  localparam func_t FN_POW = 3'd4;
  localparam func_t FN_INV = 3'd5;
  localparam func_t FN_NEG = 3'd6;
  localparam func_t FN_EQ  = 3'd7;

  // where a finished reduction is written
  localparam dst_t DST_A    = 3'd0;
  localparam dst_t DST_B    = 3'd1;
  localparam dst_t DST_ACC  = 3'd2;
  localparam dst_t DST_BASE = 3'd3;
  localparam dst_t DST_RES  = 3'd4;

  localparam res_t MOD_RESET = 31'd1000000007;

endpackage

`default_nettype wire

[rtl/prime_modulus_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// prime_modulus_arithmetic_unit: modular arithmetic over a programmable modulus
// Add, sub, mul, div, pow, inverse, negate and compare, with a shared
// bit-serial reducer and a single 31x31 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Write the modulus through cfg_we / cfg_wdata while the unit is idle; it
//   resets to 1000000007. A command transfers at a clock edge with start high
//   and busy low. busy stays high until the result is shown on out_result with
//   out_valid high for exactly one cycle; the receiver cannot stall it.
// Operation:
//   Every operand reduction and every modular multiply goes through the same
//   one-bit-per-cycle remainder loop of 64 steps, with a load before it and a
//   write-back after it. add, sub, neg and equal strobe once both operands are
//   reduced; mul adds one modular multiply, and inv of zero and div by zero
//   strobe at the same point as add. pow squares and multiplies from the low
//   exponent bit up; inv and div run pow with exponent modulus-2, div adds one
//   more multiply. The unit takes one command at a time.
// Reset:
//   rst_n is synchronous, active low; it returns the sequencer to idle and
//   restores the default modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_modulus_arithmetic_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_func,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  input  wire logic [62:0] in_exponent,
  output logic             out_valid,
  output logic [30:0]      out_result,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RED   = 3'd1;
  localparam logic [2:0] S_FIX   = 3'd2;
  localparam logic [2:0] S_DISP  = 3'd3;
  localparam logic [2:0] S_POW   = 3'd4;
  localparam logic [2:0] S_MULP  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  pmau_pkg::res_t       modulus_r;
  pmau_pkg::func_t      func_r, func_nxt;
  pmau_pkg::dst_t       dst_r, dst_nxt;
  logic [63:0]          src_r, src_nxt;
  logic [63:0]          braw_r, braw_nxt;
  logic                 neg_r, neg_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  pmau_pkg::res_t       rem_r, rem_nxt;
  pmau_pkg::res_t       a_r, a_nxt, b_r, b_nxt;
  pmau_pkg::res_t       acc_r, acc_nxt, base_r, base_nxt;
  logic [62:0]          exp_r, exp_nxt;
  logic                 out_valid_nxt;
  pmau_pkg::res_t       out_result_nxt;

  // remainder step of the shared reducer
  logic [31:0] rtrial;
  logic [31:0] rdiff;
  logic [31:0] m32;
  assign m32    = {1'b0, modulus_r};
  assign rtrial = {rem_r, src_r[63]};
  assign rdiff  = rtrial - m32;

  // signed residue fix-up
  pmau_pkg::res_t fixed;
  assign fixed = (neg_r && (rem_r != '0)) ? (modulus_r - rem_r) : rem_r;

  // shared multiplier operand select
  pmau_pkg::res_t mx, my;
  logic [61:0]    prod;
  always_comb begin
    case (dst_r)
      pmau_pkg::DST_ACC:  begin mx = acc_r;  my = base_r; end
      pmau_pkg::DST_BASE: begin mx = base_r; my = base_r; end
      default: begin
        if (func_r == pmau_pkg::FN_MUL) begin
          mx = a_r; my = b_r;
        end else begin
          mx = acc_r; my = a_r;
        end
      end
    endcase
  end
  assign prod = mx * my;

  // direct results
  logic [31:0] sum, dif;
  assign sum = {1'b0, a_r} + {1'b0, b_r};
  assign dif = {1'b0, a_r} + (m32 - {1'b0, b_r});

  assign busy = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    dst_nxt        = dst_r;
    src_nxt        = src_r;
    braw_nxt       = braw_r;
    neg_nxt        = neg_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    acc_nxt        = acc_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          braw_nxt  = in_operand_b;
          exp_nxt   = in_exponent;
          neg_nxt   = in_operand_a[63];
          src_nxt   = in_operand_a[63] ? (64'd0 - in_operand_a) : in_operand_a;
          dst_nxt   = pmau_pkg::DST_A;
          rem_nxt   = '0;
          cnt_nxt   = 6'd63;
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        rem_nxt = (rtrial >= m32) ? rdiff[30:0] : rtrial[30:0];
        src_nxt = {src_r[62:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) state_nxt = S_FIX;
      end
      S_FIX: begin
        case (dst_r)
          pmau_pkg::DST_A: begin
            a_nxt     = fixed;
            neg_nxt   = braw_r[63];
            src_nxt   = braw_r[63] ? (64'd0 - braw_r) : braw_r;
            dst_nxt   = pmau_pkg::DST_B;
            rem_nxt   = '0;
            cnt_nxt   = 6'd63;
            state_nxt = S_RED;
          end
          pmau_pkg::DST_B: begin
            b_nxt     = fixed;
            state_nxt = S_DISP;
          end
          pmau_pkg::DST_ACC: begin
            acc_nxt   = fixed;
            dst_nxt   = pmau_pkg::DST_BASE;
            state_nxt = S_MULP;
          end
          pmau_pkg::DST_BASE: begin
            base_nxt  = fixed;
            exp_nxt   = {1'b0, exp_r[62:1]};
            state_nxt = S_POW;
          end
          default: begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = fixed;
            state_nxt      = S_IDLE;
          end
        endcase
      end
      S_DISP: begin
        acc_nxt   = 31'd1;
        state_nxt = S_IDLE;
        if (modulus_r < 31'd2) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = (func_r == pmau_pkg::FN_EQ) ? 31'd1 : 31'd0;
        end else begin
          unique case (func_r)
            pmau_pkg::FN_ADD: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = (sum >= m32) ? sum[30:0] - modulus_r : sum[30:0];
            end
            pmau_pkg::FN_SUB: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = (dif >= m32) ? dif[30:0] - modulus_r : dif[30:0];
            end
            pmau_pkg::FN_MUL: begin
              dst_nxt   = pmau_pkg::DST_RES;
              state_nxt = S_MULP;
            end
            pmau_pkg::FN_DIV: begin
              if (b_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_result_nxt = '0;
              end else begin
                base_nxt  = b_r;
                exp_nxt   = {32'd0, modulus_r - 31'd2};
                state_nxt = S_POW;
              end
            end
            pmau_pkg::FN_POW: begin
              base_nxt  = a_r;
              state_nxt = S_POW;
            end
            pmau_pkg::FN_INV: begin
              if (a_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_result_nxt = '0;
              end else begin
                base_nxt  = a_r;
                exp_nxt   = {32'd0, modulus_r - 31'd2};
                state_nxt = S_POW;
              end
            end
            pmau_pkg::FN_NEG: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = (a_r != '0) ? modulus_r - a_r : '0;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_result_nxt = (a_r == b_r) ? 31'd1 : 31'd0;
            end
          endcase
        end
      end
      S_POW: begin
        // square-and-multiply, low exponent bit first
        state_nxt = S_MULP;
        if (exp_r == '0) begin
          if (func_r == pmau_pkg::FN_DIV) begin
            dst_nxt = pmau_pkg::DST_RES;
          end else begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = acc_r;
            state_nxt      = S_IDLE;
          end
        end else if (exp_r[0]) begin
          dst_nxt = pmau_pkg::DST_ACC;
        end else begin
          dst_nxt = pmau_pkg::DST_BASE;
        end
      end
      S_MULP: begin
        src_nxt   = {2'b00, prod};
        neg_nxt   = 1'b0;
        rem_nxt   = '0;
        cnt_nxt   = 6'd63;
        state_nxt = S_RED;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      modulus_r <= pmau_pkg::MOD_RESET;
    end else begin
      state_r   <= state_nxt;
      out_valid <= out_valid_nxt;
      if (cfg_we) modulus_r <= cfg_wdata;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    dst_r      <= dst_nxt;
    src_r      <= src_nxt;
    braw_r     <= braw_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    exp_r      <= exp_nxt;
    out_result <= out_result_nxt;
  end

`ifndef SYNTHESIS
  // a result strobe always coincides with the return to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // an accepted command always makes the unit busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("command not taken");

  // the running remainder stays below the modulus
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RED && modulus_r >= 31'd2) |-> rem_r < modulus_r)
    else $error("remainder out of range");

  // results are reduced
  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && modulus_r >= 31'd2) |-> out_result < modulus_r)
    else $error("result not reduced");
`endif

endmodule

`default_nettype wire
